>>> sv/scrambled_base36_codec_top_macros.svh
// assertion macros for the scrambled base-36 codec
// used by the modules that carry concurrent checks, expects aclk and aresetn in scope
`ifndef SCRAMBLED_BASE36_CODEC_TOP_MACROS_SVH
`define SCRAMBLED_BASE36_CODEC_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define SBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define SBC_ASSERT(lbl, prop, msg)
`define SBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/sbc_pkg.sv
// shared types, constants and alphabet tables of the scrambled base-36 codec
// no dependencies
`default_nettype none

package sbc_pkg;

    localparam int RADIX          = 36;
    localparam int ENC_MAX_DIGITS = 7;
    localparam int CNT_W          = $clog2(ENC_MAX_DIGITS + 1);
    localparam int DIGIT_W        = $clog2(RADIX);
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam logic [29:0] DIV9_MAGIC = 30'h38E38E39;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        op_t                  op;
        logic [31:0]          value;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } cmd_t;

    function automatic logic [7:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        c = "0";
        unique case (d)
            6'd0:  c = "0";
            6'd1:  c = "o";
            6'd2:  c = "q";
            6'd3:  c = "e";
            6'd4:  c = "f";
            6'd5:  c = "6";
            6'd6:  c = "u";
            6'd7:  c = "k";
            6'd8:  c = "9";
            6'd9:  c = "4";
            6'd10: c = "d";
            6'd11: c = "7";
            6'd12: c = "r";
            6'd13: c = "2";
            6'd14: c = "s";
            6'd15: c = "y";
            6'd16: c = "t";
            6'd17: c = "5";
            6'd18: c = "3";
            6'd19: c = "i";
            6'd20: c = "v";
            6'd21: c = "1";
            6'd22: c = "w";
            6'd23: c = "l";
            6'd24: c = "p";
            6'd25: c = "j";
            6'd26: c = "x";
            6'd27: c = "c";
            6'd28: c = "z";
            6'd29: c = "g";
            6'd30: c = "m";
            6'd31: c = "n";
            6'd32: c = "a";
            6'd33: c = "h";
            6'd34: c = "b";
            6'd35: c = "8";
            default: c = "0";
        endcase
        return c;
    endfunction

    // bytes outside the alphabet map to digit zero
    function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = '0;
        unique case (c)
            "0": d = 6'd0;
            "o": d = 6'd1;
            "q": d = 6'd2;
            "e": d = 6'd3;
            "f": d = 6'd4;
            "6": d = 6'd5;
            "u": d = 6'd6;
            "k": d = 6'd7;
            "9": d = 6'd8;
            "4": d = 6'd9;
            "d": d = 6'd10;
            "7": d = 6'd11;
            "r": d = 6'd12;
            "2": d = 6'd13;
            "s": d = 6'd14;
            "y": d = 6'd15;
            "t": d = 6'd16;
            "5": d = 6'd17;
            "3": d = 6'd18;
            "i": d = 6'd19;
            "v": d = 6'd20;
            "1": d = 6'd21;
            "w": d = 6'd22;
            "l": d = 6'd23;
            "p": d = 6'd24;
            "j": d = 6'd25;
            "x": d = 6'd26;
            "c": d = 6'd27;
            "z": d = 6'd28;
            "g": d = 6'd29;
            "m": d = 6'd30;
            "n": d = 6'd31;
            "a": d = 6'd32;
            "h": d = 6'd33;
            "b": d = 6'd34;
            "8": d = 6'd35;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> sv/scrambled_base36_codec_top.sv
// top level of the scrambled base-36 codec: front end, command queue, back end
// depends on sbc_pkg, sbc_front, sbc_queue, sbc_back
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  s_       | in        | s_valid / s_ready  | operation, value_in, char_in, last_char
//  m_       | out       | m_valid / m_ready  | char_out, value_out, is_decode, last_out
//
// an encode of a value with n base-36 digits (n from 1 to 7) passes through the back end in turn:
// it takes the command, runs n steps of the divide-by-36 multiplier, then emits n characters
// each decode character is folded into the back end's shift-add accumulator
// the four-entry command queue takes items until full while the back end is busy or stalled
// reset (aresetn low, synchronous) empties the queue, clears the accumulator and drops output
// a stalled result sits in the output register; the back end waits only for that register
`default_nettype none

module scrambled_base36_codec_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_operation,
    input  wire logic [31:0]  s_value_in,
    input  wire logic [7:0]   s_char_in,
    input  wire logic         s_last_char,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_char_out,
    output logic [31:0]       m_value_out,
    output logic              m_is_decode,
    output logic              m_last_out
);

    logic            q_full;
    logic            q_push;
    sbc_pkg::cmd_t   q_cmd;
    logic            q_pop;
    logic            q_head_valid;
    sbc_pkg::cmd_t   q_head_cmd;

    sbc_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value_in  (s_value_in),
        .s_char_in   (s_char_in),
        .s_last_char (s_last_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    sbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    sbc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_head_valid),
        .q_cmd       (q_head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_value_out (m_value_out),
        .m_is_decode (m_is_decode),
        .m_last_out  (m_last_out)
    );

endmodule

`default_nettype wire

>>> sv/sbc_front.sv
// front end: accepts input items, maps decode bytes to digits, builds queue commands
// depends on sbc_pkg
`default_nettype none

module sbc_front (
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_operation,
    input  wire logic [31:0]  s_value_in,
    input  wire logic [7:0]   s_char_in,
    input  wire logic         s_last_char,
    input  wire logic         q_full,
    output logic              q_push,
    output sbc_pkg::cmd_t     q_cmd
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.op    = sbc_pkg::op_t'(s_operation);
        q_cmd.value = s_value_in;
        q_cmd.digit = sbc_pkg::char_to_digit(s_char_in);
        q_cmd.last  = s_last_char;
    end

endmodule

`default_nettype wire

>>> sv/sbc_queue.sv
// short command queue between front and back end
// depends on sbc_pkg
`default_nettype none

module sbc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sbc_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sbc_pkg::cmd_t      head_cmd
);

    sbc_pkg::cmd_t                 entry_reg [sbc_pkg::QDEPTH];
    logic [sbc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sbc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sbc_pkg::QPTR_W:0]      count_reg, count_next;
    logic                          do_push, do_pop;

    assign full       = (count_reg == (sbc_pkg::QPTR_W+1)'(sbc_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/sbc_back.sv
// back end: digit extraction and emission for encode, horner accumulation for decode
// depends on sbc_pkg and the assertion macro header
`default_nettype none
`include "scrambled_base36_codec_top_macros.svh"

module sbc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire sbc_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_char_out,
    output logic [31:0]        m_value_out,
    output logic               m_is_decode,
    output logic               m_last_out
);

    sbc_pkg::back_state_t            state_reg, state_next;
    logic [31:0]                     acc_reg, acc_next;
    logic [31:0]                     work_reg, work_next;
    logic [sbc_pkg::DIGIT_W-1:0]     dig_reg [sbc_pkg::ENC_MAX_DIGITS];
    logic [sbc_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      m_char_out_reg, m_char_out_next;
    logic [31:0]                     m_value_out_reg, m_value_out_next;
    logic                            m_is_decode_reg, m_is_decode_next;
    logic                            m_last_out_reg, m_last_out_next;

    logic                            out_free;
    logic [59:0]                     div_prod;
    logic [31:0]                     quot;
    logic [31:0]                     quot_x36;
    logic [sbc_pkg::DIGIT_W-1:0]     rem;
    logic [sbc_pkg::CNT_W-1:0]       emit_idx;
    logic                            div_done;
    logic                            dig_we;

    assign out_free = !m_valid_reg || m_ready;

    // divide by 36 as a shift by two and a reciprocal multiply for nine
    assign div_prod = work_reg[31:2] * sbc_pkg::DIV9_MAGIC;
    assign quot     = {5'b0, div_prod[59:33]};
    assign quot_x36 = {quot[26:0], 5'b0} + {quot[29:0], 2'b0};
    assign rem      = sbc_pkg::DIGIT_W'(work_reg - quot_x36);
    assign div_done = (quot == '0)
                   || (cnt_reg == sbc_pkg::CNT_W'(sbc_pkg::ENC_MAX_DIGITS - 1));
    assign emit_idx = cnt_reg - 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbc_pkg::BK_IDLE: begin
                if (q_valid && q_cmd.op == sbc_pkg::OP_ENCODE) begin
                    state_next = sbc_pkg::BK_DIV;
                end
            end
            sbc_pkg::BK_DIV: begin
                if (div_done) begin
                    state_next = sbc_pkg::BK_EMIT;
                end
            end
            sbc_pkg::BK_EMIT: begin
                if (out_free && cnt_reg == sbc_pkg::CNT_W'(1)) begin
                    state_next = sbc_pkg::BK_IDLE;
                end
            end
            default: state_next = sbc_pkg::BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        q_pop            = 1'b0;
        acc_next         = acc_reg;
        work_next        = work_reg;
        cnt_next         = cnt_reg;
        dig_we           = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_char_out_next  = m_char_out_reg;
        m_value_out_next = m_value_out_reg;
        m_is_decode_next = m_is_decode_reg;
        m_last_out_next  = m_last_out_reg;
        unique case (state_reg)
            sbc_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.op == sbc_pkg::OP_ENCODE) begin
                        q_pop     = 1'b1;
                        work_next = q_cmd.value;
                        cnt_next  = '0;
                    end else if (!q_cmd.last) begin
                        q_pop    = 1'b1;
                        acc_next = {acc_reg[26:0], 5'b0} + {acc_reg[29:0], 2'b0}
                                 + {26'b0, q_cmd.digit};
                    end else if (out_free) begin
                        q_pop            = 1'b1;
                        acc_next         = '0;
                        m_valid_next     = 1'b1;
                        m_char_out_next  = '0;
                        m_value_out_next = {acc_reg[26:0], 5'b0} + {acc_reg[29:0], 2'b0}
                                         + {26'b0, q_cmd.digit};
                        m_is_decode_next = 1'b1;
                        m_last_out_next  = 1'b1;
                    end
                end
            end
            sbc_pkg::BK_DIV: begin
                dig_we    = 1'b1;
                work_next = quot;
                cnt_next  = cnt_reg + 1'b1;
            end
            sbc_pkg::BK_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_out_next  = sbc_pkg::digit_to_char(dig_reg[emit_idx]);
                    m_value_out_next = '0;
                    m_is_decode_next = 1'b0;
                    m_last_out_next  = (cnt_reg == sbc_pkg::CNT_W'(1));
                    cnt_next         = emit_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbc_pkg::BK_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg        <= work_next;
        m_char_out_reg  <= m_char_out_next;
        m_value_out_reg <= m_value_out_next;
        m_is_decode_reg <= m_is_decode_next;
        m_last_out_reg  <= m_last_out_next;
        if (dig_we) begin
            dig_reg[cnt_reg] <= rem;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_out  = m_char_out_reg;
    assign m_value_out = m_value_out_reg;
    assign m_is_decode = m_is_decode_reg;
    assign m_last_out  = m_last_out_reg;

    `SBC_ASSERT(a_emit_has_digits,
        (state_reg == sbc_pkg::BK_EMIT) |-> (cnt_reg != '0), "emit with no digits left")
    `SBC_ASSERT(a_div_in_range,
        (state_reg == sbc_pkg::BK_DIV)
            |-> (cnt_reg < sbc_pkg::CNT_W'(sbc_pkg::ENC_MAX_DIGITS)),
        "digit count overrun")
    `SBC_ASSERT(a_acc_cleared,
        (q_pop && q_cmd.op == sbc_pkg::OP_DECODE && q_cmd.last) |=> (acc_reg == '0),
        "accumulator not cleared after last char")
    `SBC_ASSERT(a_decode_is_last,
        (m_valid_reg && m_is_decode_reg) |-> m_last_out_reg, "decode result without last mark")
    `SBC_ASSERT(a_pop_only_idle,
        q_pop |-> (state_reg == sbc_pkg::BK_IDLE && q_valid), "queue popped outside idle")

endmodule

`default_nettype wire
